### sv/spi_register_master_core_defines.svh
// ----------------------------------------------------------------------------
// SPI register master assertion macros
// Shared property forms used by the checker of the SPI register master.
// ----------------------------------------------------------------------------
`ifndef SPI_REGISTER_MASTER_CORE_DEFINES_SVH
`define SPI_REGISTER_MASTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define SRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define SRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define SRM_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/srm_pkg.sv
// ----------------------------------------------------------------------------
// SPI register master package
// Command codes, sequencer phases and the state and result records shared
// by the sequencer step logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package srm_pkg;

  // Command codes carried with each request.
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_BBEGIN = 3'd3;
  localparam logic [2:0] OP_BREAD  = 3'd4;
  localparam logic [2:0] OP_BEND   = 3'd5;

  // Protocol constants.
  localparam logic [7:0] WRITE_FLAG = 8'h80;
  localparam logic [7:0] BURST_REG  = 8'h3C;

  // Bits per frame.
  localparam logic [4:0] BITS_REG   = 5'd16;
  localparam logic [4:0] BITS_BURST = 5'd8;

  localparam int unsigned HALF_W          = 16;
  localparam logic [HALF_W-1:0] HALF_RESET = 16'd1;

  // Sequencer phase, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LOW  = 3'b010,
    PH_HIGH = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  active_cmd;
    logic [4:0]  bit_cnt;
    logic [15:0] half_cnt;
    logic [15:0] tx_shift;
    logic [7:0]  rx_shift;
    logic        sel_slave;
    logic [1:0]  sel_levels;
  } seq_state_t;

  typedef struct packed {
    logic       sclk;
    logic       mosi;
    logic       select_first_n;
    logic       select_second_n;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       command_done;
    logic       command_rejected;
  } seq_result_t;

endpackage

`default_nettype wire

### sv/spi_register_master_core.sv
// A request's result appears in the output register in the cycle after it is accepted.
// Throughput: one request per cycle unless the result stalls; sequencer state and output
// register both update in the accepting cycle, and in_tready stays high while results drain.
// Reset: synchronous, active low; both selects high, sequencer idle, half period of one tick.
// ----------------------------------------------------------------------------
// SPI register master core
// Mode-0 SPI master for two slaves, advanced by one clock tick per request.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_register_master_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Configuration: half period length in ticks.
  input  wire logic                       cfg_wr_en,
  input  wire logic [srm_pkg::HALF_W-1:0] cfg_wr_data,
  // Request channel.
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // tdata: reg_address[7:0], write_data[15:8], miso[16], zero pad[23:17]
  input  wire logic [23:0]                in_tdata,
  // tuser: operation[2:0], chip_select[3]
  input  wire logic [3:0]                 in_tuser,
  // Result channel.
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // tdata: sclk[0], mosi[1], select_first_n[2], select_second_n[3], busy_res[4],
  //        read_valid[5], read_data[13:6], command_done[14], command_rejected[15]
  output logic [15:0]                     out_tdata
);
  import srm_pkg::*;

  logic [HALF_W-1:0] half_r;
  logic [HALF_W-1:0] half_nxt;
  seq_state_t        state_r;
  seq_state_t        state_nxt;
  seq_result_t       res_r;
  seq_result_t       res_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              accept;

  // The result register frees up in the same cycle that it is taken.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Configuration write.
  assign half_nxt = cfg_wr_en ? cfg_wr_data : half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_RESET;
    end else begin
      half_r <= half_nxt;
    end
  end

  // Sequencer step for the incoming tick.
  srm_step u_step (
    .half_period (half_r),
    .operation   (in_tuser[2:0]),
    .chip_select (in_tuser[3]),
    .reg_address (in_tdata[7:0]),
    .write_data  (in_tdata[15:8]),
    .miso        (in_tdata[16]),
    .cur         (state_r),
    .nxt         (state_nxt),
    .res         (res_nxt)
  );

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, active_cmd: 3'd0, bit_cnt: 5'd0, half_cnt: 16'd0,
                   tx_shift: 16'd0, rx_shift: 8'd0, sel_slave: 1'b0,
                   sel_levels: 2'b11};
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  assign out_valid_nxt = accept ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.command_rejected, res_r.command_done, res_r.read_data,
                       res_r.read_valid, res_r.busy_res, res_r.select_second_n,
                       res_r.select_first_n, res_r.mosi, res_r.sclk};

endmodule

`default_nettype wire

### sv/srm_step.sv
// ----------------------------------------------------------------------------
// SPI register master sequencer step
// Combinational next-state and pin-level logic for one clock tick request.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_step (
  input  wire logic [srm_pkg::HALF_W-1:0] half_period,
  input  wire logic [2:0]                 operation,
  input  wire logic                       chip_select,
  input  wire logic [7:0]                 reg_address,
  input  wire logic [7:0]                 write_data,
  input  wire logic                       miso,
  input  wire srm_pkg::seq_state_t        cur,
  output srm_pkg::seq_state_t             nxt,
  output srm_pkg::seq_result_t            res
);
  import srm_pkg::*;

  logic [HALF_W-1:0] half;
  logic              is_cmd;
  logic              reg_cmd;
  logic [4:0]        total;
  logic [4:0]        bit_inc;
  logic              done;
  logic              valid;
  logic              rejected;
  logic [7:0]        rdata;

  // A zero half period behaves as one tick.
  assign half   = (half_period == '0) ? HALF_RESET : half_period;
  assign is_cmd = (operation == OP_READ) || (operation == OP_WRITE) ||
                  (operation == OP_BBEGIN) || (operation == OP_BREAD) ||
                  (operation == OP_BEND);
  assign reg_cmd = (cur.active_cmd == OP_READ) || (cur.active_cmd == OP_WRITE);
  assign total   = reg_cmd ? BITS_REG : BITS_BURST;
  assign bit_inc = cur.bit_cnt + 5'd1;

  // Sequencer update for this tick.
  always_comb begin
    nxt      = cur;
    done     = 1'b0;
    valid    = 1'b0;
    rejected = 1'b0;
    rdata    = 8'd0;
    case (cur.phase)
      PH_IDLE: begin
        if (is_cmd) begin
          nxt.sel_slave = chip_select;
          if (operation == OP_BEND) begin
            nxt.sel_levels[chip_select] = 1'b1;
            done = 1'b1;
          end else begin
            case (operation)
              OP_READ:   nxt.tx_shift = {reg_address, 8'd0};
              OP_WRITE:  nxt.tx_shift = {reg_address | WRITE_FLAG, write_data};
              OP_BBEGIN: nxt.tx_shift = {BURST_REG, 8'd0};
              default:   nxt.tx_shift = 16'd0;
            endcase
            if (operation != OP_BREAD) begin
              nxt.sel_levels[chip_select] = 1'b0;
            end
            nxt.active_cmd = operation;
            nxt.bit_cnt    = 5'd0;
            nxt.half_cnt   = 16'd1;
            nxt.rx_shift   = 8'd0;
            nxt.phase      = PH_LOW;
          end
        end
      end
      PH_LOW, PH_HIGH: begin
        rejected = is_cmd;
        if (cur.half_cnt >= half) begin
          if (cur.phase == PH_LOW) begin
            // Rising edge: sample MISO.
            nxt.phase    = PH_HIGH;
            nxt.half_cnt = 16'd1;
            nxt.rx_shift = {cur.rx_shift[6:0], miso};
          end else begin
            nxt.bit_cnt = bit_inc;
            if (bit_inc >= total) begin
              nxt.phase    = PH_IDLE;
              nxt.tx_shift = 16'd0;
              nxt.half_cnt = 16'd0;
              if (reg_cmd) begin
                nxt.sel_levels[cur.sel_slave] = 1'b1;
              end
              if ((cur.active_cmd == OP_READ) || (cur.active_cmd == OP_BREAD)) begin
                valid = 1'b1;
                rdata = cur.rx_shift;
              end
              done = 1'b1;
            end else begin
              nxt.phase    = PH_LOW;
              nxt.half_cnt = 16'd1;
              nxt.tx_shift = {cur.tx_shift[14:0], 1'b0};
            end
          end
        end else begin
          nxt.half_cnt = cur.half_cnt + 16'd1;
        end
      end
      default: begin
        nxt.phase = PH_IDLE;
      end
    endcase
  end

  // Pin levels after this tick.
  always_comb begin
    res.sclk             = (nxt.phase == PH_HIGH);
    res.mosi             = (nxt.phase != PH_IDLE) && nxt.tx_shift[15];
    res.select_first_n   = nxt.sel_levels[0];
    res.select_second_n  = nxt.sel_levels[1];
    res.busy_res         = (nxt.phase != PH_IDLE);
    res.read_valid       = valid;
    res.read_data        = rdata;
    res.command_done     = done;
    res.command_rejected = rejected;
  end

endmodule

`default_nettype wire

### sv/srm_checker.sv
// ----------------------------------------------------------------------------
// SPI register master port checker
// Watches the top-level ports for consistency of the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spi_register_master_core_defines.svh"

module srm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // A received byte always closes a command.
  `SRM_ASSERT_NOW(a_valid_done, out_tvalid && out_tdata[5], out_tdata[14], "read_valid without command_done")

  // While idle the serial clock and data line rest low.
  `SRM_ASSERT_NOW(a_idle_lines, out_tvalid && !out_tdata[4], !out_tdata[0] && !out_tdata[1], "sclk or mosi high while idle")

  // Read data is zero unless it is flagged valid.
  `SRM_ASSERT_NOW(a_rdata_zero, out_tvalid && !out_tdata[5], out_tdata[13:6] == 8'd0, "read_data set without read_valid")

  // A stalled result holds.
  `SRM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // No result is offered straight after reset.
  `SRM_ASSERT_ALWAYS_NEXT(a_reset_quiet, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind spi_register_master_core srm_checker u_srm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### tb/sv/spi_register_master_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI register master core testbench
// Drives tick requests carrying register, burst and idle commands through the
// request channel and checks every pin-level result against a cycle-true
// model of the mode-0 sequencer held in a small scoreboard class. Both sides
// of the stream idle at random, and the half period is changed between
// phases, including while a command is still in progress.
// ----------------------------------------------------------------------------

module spi_register_master_core_tb;
  import srm_pkg::*;

  // Operation codes that the block treats as plain ticks.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  // How the MISO level is chosen for the ticks of a directed command.
  localparam logic [1:0] MISO_LOW    = 2'd0;
  localparam logic [1:0] MISO_HIGH   = 2'd1;
  localparam logic [1:0] MISO_RANDOM = 2'd2;

  localparam int MAX_REPORTS = 10;

  // Scoreboard: tracks the sequencer and holds the expected pin levels.
  class pin_level_scoreboard;
    phase_t      phase;
    logic [2:0]  cmd;
    logic [4:0]  bit_cnt;
    logic [15:0] half_cnt;
    logic [15:0] tx;
    logic [7:0]  rx;
    logic        slave;
    logic [1:0]  sel;
    logic [15:0] half_ticks;
    seq_result_t expected_levels[$];
    int          mismatches;

    function new();
      phase      = PH_IDLE;
      cmd        = OP_TICK;
      bit_cnt    = '0;
      half_cnt   = '0;
      tx         = '0;
      rx         = '0;
      slave      = 1'b0;
      sel        = 2'b11;
      half_ticks = HALF_RESET;
      mismatches = 0;
    endfunction

    function void set_half_period(logic [15:0] value);
      half_ticks = value;
    endfunction

    // A half period of zero behaves as one tick.
    function logic [15:0] eff_half();
      return (half_ticks == 16'd0) ? 16'd1 : half_ticks;
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    // True when the next request lands on the tick that ends the command.
    function bit finishing();
      logic [4:0] total;
      total = (cmd == OP_READ || cmd == OP_WRITE) ? BITS_REG : BITS_BURST;
      return phase == PH_HIGH && half_cnt >= eff_half() && (bit_cnt + 5'd1) >= total;
    endfunction

    // Advances the sequencer by one accepted request and queues the levels.
    function void note_request(logic [2:0] op, logic cs, logic [7:0] addr,
                               logic [7:0] wdata, logic miso);
      bit          is_cmd;
      logic [4:0]  total;
      seq_result_t res;
      is_cmd = (op >= OP_READ && op <= OP_BEND);
      res = '0;
      if (phase == PH_IDLE) begin
        if (is_cmd) begin
          slave = cs;
          if (op == OP_BEND) begin
            sel[cs] = 1'b1;
            res.command_done = 1'b1;
          end else begin
            case (op)
              OP_READ:   tx = {addr, 8'h00};
              OP_WRITE:  tx = {addr | WRITE_FLAG, wdata};
              OP_BBEGIN: tx = {BURST_REG, 8'h00};
              default:   tx = '0;
            endcase
            if (op != OP_BREAD) sel[cs] = 1'b0;
            cmd      = op;
            bit_cnt  = '0;
            half_cnt = 16'd1;
            rx       = '0;
            phase    = PH_LOW;
          end
        end
      end else begin
        if (is_cmd) res.command_rejected = 1'b1;
        if (half_cnt >= eff_half()) begin
          if (phase == PH_LOW) begin
            // Rising edge of SCLK: MISO is sampled here.
            phase    = PH_HIGH;
            half_cnt = 16'd1;
            rx       = {rx[6:0], miso};
          end else begin
            total   = (cmd == OP_READ || cmd == OP_WRITE) ? BITS_REG : BITS_BURST;
            bit_cnt = bit_cnt + 5'd1;
            if (bit_cnt >= total) begin
              phase    = PH_IDLE;
              tx       = '0;
              half_cnt = '0;
              if (cmd == OP_READ || cmd == OP_WRITE) sel[slave] = 1'b1;
              if (cmd == OP_READ || cmd == OP_BREAD) begin
                res.read_valid = 1'b1;
                res.read_data  = rx;
              end
              res.command_done = 1'b1;
            end else begin
              phase    = PH_LOW;
              half_cnt = 16'd1;
              tx       = tx << 1;
            end
          end
        end else begin
          half_cnt = half_cnt + 16'd1;
        end
      end
      res.sclk            = (phase == PH_HIGH);
      res.mosi            = (phase != PH_IDLE) ? tx[15] : 1'b0;
      res.select_first_n  = sel[0];
      res.select_second_n = sel[1];
      res.busy_res        = (phase != PH_IDLE);
      expected_levels.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_levels(logic [15:0] data);
      seq_result_t want;
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %04h arrived with nothing expected", $time, data);
        return;
      end
      want = expected_levels.pop_front();
      compare_field("sclk", want.sclk, data[0]);
      compare_field("mosi", want.mosi, data[1]);
      compare_field("select_first_n", want.select_first_n, data[2]);
      compare_field("select_second_n", want.select_second_n, data[3]);
      compare_field("busy_res", want.busy_res, data[4]);
      compare_field("read_valid", want.read_valid, data[5]);
      compare_field("read_data", want.read_data, data[13:6]);
      compare_field("command_done", want.command_done, data[14]);
      compare_field("command_rejected", want.command_rejected, data[15]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int  send_idle_pct = 28;
  int  recv_stall_pct = 65;
  bit  burst_open = 1'b0;
  logic burst_cs = 1'b0;

  pin_level_scoreboard sb;

  spi_register_master_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: check each accepted result and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_levels(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one request, with random idle cycles first, and waits for it to go.
  task automatic send_request(logic [2:0] op, logic cs, logic [7:0] addr,
                              logic [7:0] wdata, logic miso);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, miso, wdata, addr};
    in_tuser  <= {cs, op};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, cs, addr, wdata, miso);
  endtask

  function automatic logic [2:0] spare_op();
    case ($urandom_range(2))
      0:       return OP_TICK;
      1:       return OP_SPARE_A;
      default: return OP_SPARE_B;
    endcase
  endfunction

  // Ticks until the sequencer is idle; with intrusions, stray commands are
  // thrown in now and then and always on the finishing tick.
  task automatic finish_command(logic [1:0] miso_sel, bit intrude);
    logic [2:0] op;
    logic       miso;
    while (sb.busy()) begin
      op = OP_TICK;
      if (intrude && (sb.finishing() || $urandom_range(7) == 0))
        op = 3'($urandom_range(int'(OP_BEND), int'(OP_READ)));
      miso = (miso_sel == MISO_RANDOM) ? 1'($urandom_range(1)) : miso_sel[0];
      send_request(op, 1'($urandom_range(1)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), miso);
    end
  endtask

  task automatic run_command(logic [2:0] op, logic cs, logic [7:0] addr, logic [7:0] wdata,
                             logic [1:0] miso_sel, bit intrude);
    send_request(op, cs, addr, wdata, 1'($urandom_range(1)));
    finish_command(miso_sel, intrude);
  endtask

  // Writes the half period once every expected result has arrived.
  task automatic write_half_period(logic [15:0] value);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_half_period(value);
  endtask

  // Random traffic: mostly well-formed commands and bursts, with stray
  // commands while busy and a few spare operation codes.
  task automatic random_traffic(int count);
    int         sent;
    int         r;
    logic [2:0] op;
    logic       cs;
    sent = 0;
    while (sent < count) begin
      r  = $urandom_range(99);
      cs = 1'($urandom_range(1));
      if (!sb.busy()) begin
        if (burst_open) begin
          cs = burst_cs;
          if (r < 65) op = OP_BREAD;
          else if (r < 85) begin
            op = OP_BEND;
            burst_open = 1'b0;
          end else op = spare_op();
        end else if (r < 30) op = OP_READ;
        else if (r < 55) op = OP_WRITE;
        else if (r < 70) begin
          op = OP_BBEGIN;
          burst_open = 1'b1;
          burst_cs = cs;
        end else if (r < 75) op = OP_BREAD;
        else if (r < 80) op = OP_BEND;
        else op = spare_op();
      end else if (r < 4 || (sb.finishing() && r < 15)) begin
        op = 3'($urandom_range(int'(OP_BEND), int'(OP_READ)));
      end else if (r < 7) begin
        op = spare_op();
      end else begin
        op = OP_TICK;
      end
      send_request(op, cs, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      sent++;
    end
  endtask

  // Main sequence.
  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: spare codes, field extremes, bursts and rejections.
    send_request(OP_TICK, 1'b0, 8'h00, 8'h00, 1'b0);
    send_request(OP_SPARE_A, 1'b1, 8'hFF, 8'hFF, 1'b1);
    send_request(OP_SPARE_B, 1'b0, 8'h00, 8'hFF, 1'b0);
    run_command(OP_READ, 1'b0, 8'hFF, 8'h00, MISO_HIGH, 1'b0);
    run_command(OP_READ, 1'b1, 8'h00, 8'hFF, MISO_LOW, 1'b0);
    run_command(OP_WRITE, 1'b1, 8'h00, 8'hFF, MISO_RANDOM, 1'b1);
    run_command(OP_WRITE, 1'b0, 8'hFF, 8'h00, MISO_RANDOM, 1'b0);
    run_command(OP_BBEGIN, 1'b0, 8'h12, 8'h34, MISO_RANDOM, 1'b0);
    run_command(OP_BREAD, 1'b0, 8'h56, 8'h78, MISO_RANDOM, 1'b1);
    // A burst read on the second slave, which is not selected.
    run_command(OP_BREAD, 1'b1, 8'h9A, 8'hBC, MISO_RANDOM, 1'b0);
    run_command(OP_BEND, 1'b0, 8'hDE, 8'hF0, MISO_RANDOM, 1'b0);
    // Ending a burst on a slave that is already deselected.
    run_command(OP_BEND, 1'b1, 8'h0F, 8'hE1, MISO_RANDOM, 1'b0);

    // A zero half period behaves as one tick.
    write_half_period(16'd0);
    run_command(OP_READ, 1'b0, 8'h5A, 8'hA5, MISO_RANDOM, 1'b1);

    // Longest half period, then shortened mid-command so the running half
    // ends at once.
    write_half_period(16'hFFFF);
    send_request(OP_READ, 1'b1, 8'hC3, 8'h3C, 1'b1);
    repeat (12) send_request(OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 1'($urandom_range(1)));
    write_half_period(16'd1);
    finish_command(MISO_RANDOM, 1'b1);

    random_traffic(370);

    // Sender and receiver swap their idle rates.
    send_idle_pct  = 65;
    recv_stall_pct = 28;
    write_half_period(16'($urandom_range(4, 2)));
    random_traffic(370);

    // No idling from here on.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_half_period(16'd1);
    random_traffic(300);
    write_half_period(16'd2);
    random_traffic(260);

    // Drain and report.
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
